[hdl/qpqw_pkg.sv]
// qpqw_pkg: shared widths, status codes and state encoding for the quad q-weight block
// no dependencies
package qpqw_pkg;
  localparam int unsigned QFracBits = 16;
  localparam int unsigned OutW      = 24;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ProdW     = 42;
  localparam int unsigned QuotW     = ProdW + QFracBits;
  localparam logic [OutW-1:0] OutMax = {OutW{1'b1}};

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoCross  = 2'd1,
    StZeroDist = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SCross = 8'b00000010,
    SCheck = 8'b00000100,
    SDiv   = 8'b00001000,
    SMulU  = 8'b00010000,
    SMulV  = 8'b00100000,
    SEmit  = 8'b01000000,
    SStart = 8'b10000000
  } state_e;
endpackage

[hdl/qpqw_serial_mul.sv]
// qpqw_serial_mul: shift-and-add multiplier, one multiplier bit per cycle
// depends on qpqw_pkg
module qpqw_serial_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [qpqw_pkg::ProdW-1:0] a_i,
  input  logic signed [qpqw_pkg::ProdW-1:0] b_i,
  output logic                              done_o,
  output logic signed [qpqw_pkg::ProdW-1:0] p_o
);
  localparam int unsigned W = qpqw_pkg::ProdW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic signed [W-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [W-1:0]        mp_q, mp_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q; mc_d = mc_q; mp_d = mp_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; mc_d = a_i; mp_d = b_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      // top multiplier bit carries negative weight
      if (mp_q[0]) begin
        if (cnt_q == CntW'(W - 1)) acc_d = acc_q - mc_q;
        else acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(W - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mc_q <= mc_d; mp_q <= mp_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("multiplier done held");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("multiplier busy at done");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < CntW'(W)) else $error("multiplier count overrun");
endmodule

[hdl/qpqw_serial_div.sv]
// qpqw_serial_div: restoring divider, one quotient bit per cycle, rounds half up
// depends on qpqw_pkg
module qpqw_serial_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [qpqw_pkg::ProdW-1:0]      num_i,
  input  logic [qpqw_pkg::ProdW-1:0]      den_i,
  output logic                            done_o,
  output logic [qpqw_pkg::OutW-1:0]       q_o
);
  localparam int unsigned QW = qpqw_pkg::QuotW;
  localparam int unsigned DW = qpqw_pkg::ProdW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [QW-1:0]   quo_q, quo_d;
  logic [DW:0]     rem_q, rem_d, trial;
  logic [DW-1:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DW:0]     rem2;
  logic [QW:0]     rounded;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DW-1:0], quo_q[QW-1]};
    if (start_i) begin
      quo_d = {num_i, {qpqw_pkg::QFracBits{1'b0}}};
      rem_d = '0; den_d = den_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(QW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  // round half up: add one when 2*rem >= den
  assign rem2    = {rem_q[DW-1:0], 1'b0};
  assign rounded = {1'b0, quo_q} + {{QW{1'b0}}, (rem2 >= {1'b0, den_q})};
  assign q_o     = (rounded > {{(QW+1-qpqw_pkg::OutW){1'b0}}, qpqw_pkg::OutMax})
                   ? qpqw_pkg::OutMax : rounded[qpqw_pkg::OutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && den_q != '0) |-> rem_q < {1'b0, den_q}) else $error("remainder too big");
  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy at done");
endmodule

[hdl/quad_projective_q_weights.sv]
// quad_projective_q_weights: top level, corner store, sequencer and output register
// depends on qpqw_pkg, qpqw_serial_mul, qpqw_serial_div
//
// Each request writes one corner; a request with compute_now set then starts the sequence
// that yields four results, corners 0 to 3. The time is set by one bit-serial 42-bit
// multiplier (six products for the cross terms, then two per corner for u and v) and one
// bit-serial 58-bit divider (one division per corner); when the status is not ok (the
// diagonals miss, or a corner lies on a diagonal) no division runs. A result still waiting
// in the output register holds the next corner back. Requests without compute_now only
// store their corner.
module quad_projective_q_weights (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  corner_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0] tex_u_i,
  input  logic [15:0] tex_v_i,
  input  logic        compute_now_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  out_corner_o,
  output logic [23:0] scaled_u_o,
  output logic [23:0] scaled_v_o,
  output logic [23:0] q_weight_o,
  output logic [1:0]  status_o,
  output logic        final_result_o
);
  localparam int unsigned PW = qpqw_pkg::ProdW;
  localparam int unsigned OW = qpqw_pkg::OutW;
  localparam int unsigned OneW = qpqw_pkg::QFracBits + 1;
  localparam logic [OneW-1:0] OneRaw = {1'b1, {qpqw_pkg::QFracBits{1'b0}}};

  logic signed [15:0] px_q [4];
  logic signed [15:0] py_q [4];
  logic [15:0] tu_q [4];
  logic [15:0] tv_q [4];

  qpqw_pkg::state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] idx_q, idx_d;
  logic signed [PW-1:0] den_q, den_d, ta_q, ta_d, tb_q, tb_d, tmp_q, tmp_d;
  logic [OW-1:0] qw_q, qw_d, su_q, su_d;
  logic [1:0] st_q, st_d;
  logic valid_q, valid_d;
  logic [1:0] oc_q;
  logic [OW-1:0] ou_q, ov_q, oq_q;
  logic [1:0] ost_q;
  logic ofin_q, load_out;
  // v product must stay until output register frees
  logic mulv_hold_q;

  logic mul_start, mul_done, div_start, div_done;
  logic signed [PW-1:0] mul_a, mul_b, mul_p;
  logic [PW-1:0] div_num, div_den;
  logic [OW-1:0] div_q;
  logic signed [16:0] rx, ry, sx, sy, wx, wy;
  logic [PW-1:0] den_abs, ta_use, tb_use, divisor;
  logic [PW+16:0] sc_round;
  logic [OW-1:0] sc_sat, one_q;

  assign rx = 17'(px_q[2]) - 17'(px_q[0]);
  assign ry = 17'(py_q[2]) - 17'(py_q[0]);
  assign sx = 17'(px_q[3]) - 17'(px_q[1]);
  assign sy = 17'(py_q[3]) - 17'(py_q[1]);
  assign wx = 17'(px_q[1]) - 17'(px_q[0]);
  assign wy = 17'(py_q[1]) - 17'(py_q[0]);

  assign one_q = (OneW > OW) ? qpqw_pkg::OutMax : OW'(OneRaw);

  assign den_abs = PW'(den_q);
  assign ta_use  = PW'(ta_q);
  assign tb_use  = PW'(tb_q);
  always_comb begin
    case (idx_d)
      2'd0:    divisor = den_abs - ta_use;
      2'd1:    divisor = den_abs - tb_use;
      2'd2:    divisor = ta_use;
      default: divisor = tb_use;
    endcase
  end
  assign div_num = den_abs;
  assign div_den = divisor;

  // texture scaling: (t*q + 2^14) >> 15, saturated
  assign sc_round = {17'b0, mul_p} + (PW+17)'(16384);
  assign sc_sat = (sc_round[PW+16:15+OW] != '0) ? qpqw_pkg::OutMax : sc_round[15+OW-1:15];

  // operands for the product that starts this cycle
  always_comb begin
    mul_a = '0; mul_b = '0;
    case (step_d)
      3'd0: begin mul_a = PW'(rx); mul_b = PW'(sy); end
      3'd1: begin mul_a = PW'(ry); mul_b = PW'(sx); end
      3'd2: begin mul_a = PW'(wx); mul_b = PW'(sy); end
      3'd3: begin mul_a = PW'(wy); mul_b = PW'(sx); end
      3'd4: begin mul_a = PW'(wx); mul_b = PW'(ry); end
      default: begin mul_a = PW'(wy); mul_b = PW'(rx); end
    endcase
    if (state_d == qpqw_pkg::SMulU) begin
      mul_a = PW'(tu_q[idx_d]); mul_b = PW'(qw_d);
    end
    if (state_d == qpqw_pkg::SMulV) begin
      mul_a = PW'(tv_q[idx_d]); mul_b = PW'(qw_d);
    end
  end

  assign ready_o = (state_q == qpqw_pkg::SIdle);

  always_comb begin
    state_d = state_q; step_d = step_q; idx_d = idx_q;
    den_d = den_q; ta_d = ta_q; tb_d = tb_q; tmp_d = tmp_q;
    qw_d = qw_q; su_d = su_q; st_d = st_q;
    mul_start = 1'b0; div_start = 1'b0; load_out = 1'b0;
    case (state_q)
      qpqw_pkg::SIdle: begin
        if (valid_i && compute_now_i) begin
          state_d = qpqw_pkg::SStart; step_d = '0; idx_d = '0;
        end
      end
      qpqw_pkg::SStart: begin
        // first cross product, once the last corner is stored
        mul_start = 1'b1; state_d = qpqw_pkg::SCross;
      end
      qpqw_pkg::SCross: begin
        if (mul_done) begin
          case (step_q)
            3'd0: tmp_d = mul_p;
            3'd1: den_d = tmp_q - mul_p;
            3'd2: tmp_d = mul_p;
            3'd3: ta_d = tmp_q - mul_p;
            3'd4: tmp_d = mul_p;
            default: tb_d = tmp_q - mul_p;
          endcase
          if (step_q == 3'd5) state_d = qpqw_pkg::SCheck;
          else begin
            step_d = step_q + 1'b1;
            mul_start = 1'b1;
          end
        end
      end
      qpqw_pkg::SCheck: begin
        if (den_q < 0) begin
          den_d = -den_q; ta_d = -ta_q; tb_d = -tb_q;
        end else begin
          if (den_q == 0 || ta_q < 0 || ta_q > den_q || tb_q < 0 || tb_q > den_q)
            st_d = qpqw_pkg::StNoCross;
          else if (ta_q == 0 || ta_q == den_q || tb_q == 0 || tb_q == den_q)
            st_d = qpqw_pkg::StZeroDist;
          else st_d = qpqw_pkg::StOk;
          state_d = qpqw_pkg::SDiv;
          if (st_d == qpqw_pkg::StOk) div_start = 1'b1;
          else begin
            qw_d = one_q; mul_start = 1'b1; state_d = qpqw_pkg::SMulU;
          end
        end
      end
      qpqw_pkg::SDiv: begin
        if (div_done) begin
          qw_d = div_q; mul_start = 1'b1; state_d = qpqw_pkg::SMulU;
        end
      end
      qpqw_pkg::SMulU: begin
        if (mul_done) begin
          su_d = sc_sat; mul_start = 1'b1; state_d = qpqw_pkg::SMulV;
        end
      end
      qpqw_pkg::SMulV: begin
        if ((mul_done || mulv_hold_q) && !valid_q) begin
          load_out = 1'b1; state_d = qpqw_pkg::SEmit;
        end
      end
      qpqw_pkg::SEmit: begin
        if (idx_q == 2'd3) state_d = qpqw_pkg::SIdle;
        else begin
          idx_d = idx_q + 1'b1;
          if (st_q == qpqw_pkg::StOk) begin
            div_start = 1'b1; state_d = qpqw_pkg::SDiv;
          end else begin
            mul_start = 1'b1; state_d = qpqw_pkg::SMulU;
          end
        end
      end
      default: state_d = qpqw_pkg::SIdle;
    endcase
  end

  qpqw_serial_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start),
    .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  qpqw_serial_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .q_o(div_q)
  );

  assign valid_d = load_out ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qpqw_pkg::SIdle; step_q <= '0; idx_q <= '0; valid_q <= 1'b0;
      mulv_hold_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= '0; py_q[i] <= '0; tu_q[i] <= '0; tv_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; step_q <= step_d; idx_q <= idx_d; valid_q <= valid_d;
      mulv_hold_q <= (state_q == qpqw_pkg::SMulV) && (mul_done || mulv_hold_q) && valid_q;
      if (valid_i && ready_o) begin
        px_q[corner_i] <= pos_x_i; py_q[corner_i] <= pos_y_i;
        tu_q[corner_i] <= tex_u_i; tv_q[corner_i] <= tex_v_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d; ta_q <= ta_d; tb_q <= tb_d; tmp_q <= tmp_d;
    qw_q <= qw_d; su_q <= su_d; st_q <= st_d;
    if (load_out) begin
      oc_q <= idx_q; ou_q <= su_q; ov_q <= sc_sat; oq_q <= qw_q;
      ost_q <= st_q; ofin_q <= (idx_q == 2'd3);
    end
  end

  assign valid_o        = valid_q;
  assign out_corner_o   = oc_q;
  assign scaled_u_o     = ou_q;
  assign scaled_v_o     = ov_q;
  assign q_weight_o     = oq_q;
  assign status_o       = ost_q;
  assign final_result_o = ofin_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !valid_q) else $error("result overwritten");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> state_q == qpqw_pkg::SIdle) else $error("ready outside idle");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done)) else $error("both units finished together");
endmodule

[test/tb_quad_projective_q_weights.sv]
// testbench for quad_projective_q_weights: random and directed corner requests, q weights
// predicted in the scoreboard class and checked per result; depends on qpqw_pkg and the rtl
module tb_quad_projective_q_weights;
  typedef struct packed {
    logic [1:0]  corner;
    logic [23:0] su;
    logic [23:0] sv;
    logic [23:0] q;
    qpqw_pkg::status_e st;
    logic        fin;
  } qres_t;

  class quad_scoreboard;
    logic [15:0] px[4], py[4], tu[4], tv[4];
    qres_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        px[i] = '0; py[i] = '0; tu[i] = '0; tv[i] = '0;
      end
      errors = 0;
    endfunction

    function logic [23:0] ratio(longint num, longint dv);
      logic [127:0] n, d, r;
      n = 128'(num) << qpqw_pkg::QFracBits;
      d = 128'(dv);
      r = (n + d / 2) / d;
      ratio = (r > 128'(qpqw_pkg::OutMax)) ? qpqw_pkg::OutMax : r[23:0];
    endfunction

    function logic [23:0] scale(logic [15:0] t, logic [23:0] q);
      logic [63:0] p;
      p = (64'(t) * 64'(q) + 64'd16384) >> 15;
      scale = (p > 64'(qpqw_pkg::OutMax)) ? qpqw_pkg::OutMax : p[23:0];
    endfunction

    function void note_request(logic [1:0] c, logic [15:0] x, logic [15:0] y,
                               logic [15:0] u, logic [15:0] v, logic go);
      longint xs[4], ys[4], rx, ry, sx, sy, wx, wy, den, ta, tb;
      logic [23:0] q[4];
      qpqw_pkg::status_e st;
      qres_t r;
      px[c] = x; py[c] = y; tu[c] = u; tv[c] = v;
      if (!go) return;
      for (int i = 0; i < 4; i++) begin
        xs[i] = longint'($signed(px[i]));
        ys[i] = longint'($signed(py[i]));
      end
      rx = xs[2] - xs[0]; ry = ys[2] - ys[0];
      sx = xs[3] - xs[1]; sy = ys[3] - ys[1];
      wx = xs[1] - xs[0]; wy = ys[1] - ys[0];
      den = rx * sy - ry * sx;
      ta = wx * sy - wy * sx;
      tb = wx * ry - wy * rx;
      if (den < 0) begin
        den = -den; ta = -ta; tb = -tb;
      end
      st = qpqw_pkg::StOk;
      if (den == 0 || ta < 0 || ta > den || tb < 0 || tb > den) st = qpqw_pkg::StNoCross;
      else if (ta == 0 || ta == den || tb == 0 || tb == den) st = qpqw_pkg::StZeroDist;
      if (st == qpqw_pkg::StOk) begin
        q[0] = ratio(den, den - ta);
        q[2] = ratio(den, ta);
        q[1] = ratio(den, den - tb);
        q[3] = ratio(den, tb);
      end else begin
        for (int i = 0; i < 4; i++)
          q[i] = (qpqw_pkg::QFracBits >= qpqw_pkg::OutW) ? qpqw_pkg::OutMax :
                 24'(1 << qpqw_pkg::QFracBits);
      end
      for (int i = 0; i < 4; i++) begin
        r.corner = 2'(i);
        r.su = scale(tu[i], q[i]);
        r.sv = scale(tv[i], q[i]);
        r.q = q[i];
        r.st = st;
        r.fin = (i == 3);
        pending.push_back(r);
      end
    endfunction

    function void check_result(qres_t got);
      qres_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.corner !== e.corner || got.su !== e.su || got.sv !== e.sv ||
          got.q !== e.q || got.st !== e.st || got.fin !== e.fin) begin
        $display("%0t mismatch, expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic valid_i, ready_o, valid_o, ready_i;
  logic [1:0] corner_i, out_corner_o, status_o;
  logic signed [15:0] pos_x_i, pos_y_i;
  logic [15:0] tex_u_i, tex_v_i;
  logic compute_now_i, final_result_o;
  logic [23:0] scaled_u_o, scaled_v_o, q_weight_o;

  quad_projective_q_weights dut (.*);

  quad_scoreboard sb;
  int send_idle, recv_stall;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_request(logic [1:0] c, logic [15:0] x, logic [15:0] y,
                              logic [15:0] u, logic [15:0] v, logic go);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    corner_i <= c; pos_x_i <= x; pos_y_i <= y;
    tex_u_i <= u; tex_v_i <= v; compute_now_i <= go;
    do @(posedge clk_i); while (!ready_o);
    sb.note_request(c, x, y, u, v, go);
  endtask

  task automatic idle_input();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_quad(logic [15:0] xs[4], logic [15:0] ys[4]);
    for (int i = 0; i < 4; i++)
      send_request(2'(i), xs[i], ys[i], 16'($urandom_range(32768)),
                   16'($urandom_range(32768)), i == 3);
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i)
        sb.check_result('{out_corner_o, scaled_u_o, scaled_v_o, q_weight_o,
                          qpqw_pkg::status_e'(status_o), final_result_o});
      ready_i <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    logic [15:0] xs[4], ys[4];
    int cx, cy, sz;
    sb = new();
    rst_ni = 1'b0; valid_i = 1'b0; ready_i = 1'b0; corner_i = '0;
    pos_x_i = '0; pos_y_i = '0; tex_u_i = '0; tex_v_i = '0; compute_now_i = 1'b0;
    send_idle = 0; recv_stall = 0; hold_off = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unwritten corners: all zeros, degenerate
    send_request(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    // square with extreme texture values
    send_request(2'd0, 16'h8000, 16'h8000, 16'd0, 16'hffff, 1'b0);
    send_request(2'd1, 16'h7fff, 16'h8000, 16'd32768, 16'd32768, 1'b0);
    send_request(2'd2, 16'h7fff, 16'h7fff, 16'hffff, 16'd0, 1'b0);
    send_request(2'd3, 16'h8000, 16'h7fff, 16'd1, 16'd32767, 1'b1);
    // strongly skewed quad, large q saturates
    send_request(2'd0, 16'd0, 16'd0, 16'hffff, 16'hffff, 1'b0);
    send_request(2'd1, 16'd1000, 16'd0, 16'hffff, 16'hffff, 1'b0);
    send_request(2'd2, 16'd1001, 16'd1000, 16'hffff, 16'hffff, 1'b0);
    send_request(2'd3, 16'd0, 16'd1, 16'hffff, 16'hffff, 1'b1);
    // diagonals meet at corner 3: zero distance
    send_request(2'd2, 16'd0, 16'd1000, 16'd100, 16'd200, 1'b0);
    send_request(2'd1, 16'd1000, 16'd1000, 16'd100, 16'd200, 1'b1);
    // corner on the other diagonal: zero distance
    send_request(2'd0, 16'd0, 16'd0, 16'd500, 16'd600, 1'b0);
    send_request(2'd1, 16'd500, 16'd500, 16'd500, 16'd600, 1'b0);
    send_request(2'd2, 16'd1000, 16'd1000, 16'd500, 16'd600, 1'b0);
    send_request(2'd3, 16'd0, 16'd1000, 16'd500, 16'd600, 1'b1);
    // corner 3 moved, negative denominator; corner 1 still on the other diagonal: zero distance
    send_request(2'd3, 16'd1000, 16'd0, 16'd7, 16'd9, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 53; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 53; end
        3: begin send_idle = 31; recv_stall = 31; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) begin
        hold_off = 1;
        fork
          begin
            repeat (3000) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int k = 0; k < 13; k++) begin
        case ($urandom_range(9))
          0, 1: begin
            for (int i = 0; i < 4; i++) begin
              xs[i] = 16'($urandom); ys[i] = 16'($urandom);
            end
            send_quad(xs, ys);
          end
          2: send_request(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 1'($urandom));
          default: begin
            // quad with one corner per quadrant around a random centre, mostly small
            sz = ($urandom_range(7) == 0) ? 16000 : $urandom_range(2000, 8);
            cx = $urandom_range(32767 - sz, sz - 32768 + 65535) - 32767;
            cy = $urandom_range(32767 - sz, sz - 32768 + 65535) - 32767;
            xs[0] = 16'(cx - $urandom_range(sz, 1)); ys[0] = 16'(cy - $urandom_range(sz, 1));
            xs[1] = 16'(cx + $urandom_range(sz, 1)); ys[1] = 16'(cy - $urandom_range(sz, 1));
            xs[2] = 16'(cx + $urandom_range(sz, 1)); ys[2] = 16'(cy + $urandom_range(sz, 1));
            xs[3] = 16'(cx - $urandom_range(sz, 1)); ys[3] = 16'(cy + $urandom_range(sz, 1));
            send_quad(xs, ys);
          end
        endcase
      end
      idle_input();
      while (sb.pending.size() != 0) @(posedge clk_i);
    end
    repeat (2000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
